// ----- src/prfl_pkg.sv -----
// Shared types and constants of the page replacement unit.
`timescale 1ns / 1ps
`default_nettype none

package prfl_pkg;

   // Configuration port geometry and register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAMES = 2'd1;

   // Victim policy codes
   localparam logic MODE_FIFO = 1'b0;
   localparam logic MODE_LRU  = 1'b1;

   // Defaults for the top-level parameters and the frame count register
   localparam int unsigned DEF_FRAMES    = 16;
   localparam int unsigned DEF_PAGE_BITS = 20;
   localparam logic [CSR_DATA_W-1:0] FRAMES_RESET = 5'd16;

   // Lookup sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LOOK = 2'b10
   } state_type;

   // Update command broadcast to every cell
   typedef struct packed {
      logic touch;   // apply the recency update this cycle
      logic load;    // write the key into the target cell (miss)
      logic fill;    // target was free: age every other valid cell
   } cell_cmd_type;

   // Priority chain carried from cell to cell; also used for the per-cell picks
   typedef struct packed {
      logic hit;
      logic free;
      logic lru;
   } chain_type;

endpackage

`default_nettype wire

// ----- src/page_replacement_fifo_lru_core.sv -----
// Top level of the page replacement unit: command port, cell chain, victim choice, counters.
//
// Usage
//   Raise start with req_page_number while busy is low; the reference is taken at that edge.
//   By the end of the next cycle the frame chain has compared the key against every managed frame,
//   picked the frame (hit, first free frame, or FIFO/LRU victim), updated tags and
//   recency ranks, and registered the result. The result beat shows on the rsp_ ports for
//   exactly one cycle with rsp_valid high, from the edge that ends the lookup cycle.
//   The receiver cannot stall; nothing is held back.
//   No new reference is taken while one is in lookup. busy covers the single lookup cycle, in
//   which the tag compare, the chain priority picks, the LRU rank search and the rank
//   update all settle; the next reference enters on the edge after the result registers.
//   Configuration: csr_ writes (index 0 policy, index 1 frame count) complete when
//   csr_valid and csr_ready are high; csr_ready is low while a lookup is in flight.
//   Indexes beyond the list are taken and dropped.
//   Reset (synchronous, active high) clears every valid bit and rank, the FIFO pointer,
//   the counters, and loads FIFO policy with all frames managed. Page tags need no
//   clearing: a tag is only read behind its valid bit.
`timescale 1ns / 1ps
`default_nettype none

module page_replacement_fifo_lru_core #(
   parameter int unsigned FRAMES    = prfl_pkg::DEF_FRAMES,
   parameter int unsigned PAGE_BITS = prfl_pkg::DEF_PAGE_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // reference command
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [19:0]                         req_page_number,
   // result beat
   output logic                                     rsp_valid,
   output logic                                     rsp_is_hit,
   output logic [3:0]                               rsp_frame_index,
   output logic                                     rsp_evicted_valid,
   output logic [19:0]                              rsp_evicted_page,
   output logic [31:0]                              rsp_hit_total,
   output logic [31:0]                              rsp_miss_total,
   output logic [31:0]                              rsp_replace_total,
   // configuration writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [prfl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [prfl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int unsigned FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;  // frame index
   localparam int unsigned RW = FW;                                  // recency rank
   localparam int unsigned NW = $clog2(FRAMES + 1);                  // frame count

   // Saturating increment for the event counters
   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   // ---------------------------------------------------------------------------------
   // Control and configuration registers
   // ---------------------------------------------------------------------------------
   prfl_pkg::state_type state_ff, state_in;
   logic                                 mode_ff;
   logic [prfl_pkg::CSR_DATA_W-1:0]      nfr_ff;
   logic [PAGE_BITS-1:0]                 key_ff;
   logic [FW-1:0]                        fifo_ptr_ff, fifo_ptr_in;
   logic [31:0]                          hit_cnt_ff, hit_cnt_in;
   logic [31:0]                          miss_cnt_ff, miss_cnt_in;
   logic [31:0]                          repl_cnt_ff, repl_cnt_in;

   logic accept;
   logic look;

   assign look      = (state_ff == prfl_pkg::ST_LOOK);
   assign busy      = look;
   assign accept    = start && !busy;
   assign csr_ready = !busy;

   always_comb begin
      unique case (state_ff)
         prfl_pkg::ST_IDLE: state_in = accept ? prfl_pkg::ST_LOOK : prfl_pkg::ST_IDLE;
         prfl_pkg::ST_LOOK: state_in = prfl_pkg::ST_IDLE;
         default:           state_in = prfl_pkg::ST_IDLE;
      endcase
   end

   // Clamp the managed frame count to 1..FRAMES
   logic [NW-1:0]   n_frames;
   logic [FRAMES-1:0] in_range;

   always_comb begin
      if (nfr_ff == '0) begin
         n_frames = NW'(1);
      end else if (int'(nfr_ff) > int'(FRAMES)) begin
         n_frames = NW'(FRAMES);
      end else begin
         n_frames = NW'(nfr_ff);
      end
      for (int i = 0; i < int'(FRAMES); i++) begin
         in_range[i] = int'(n_frames) > i;
      end
   end

   // ---------------------------------------------------------------------------------
   // Cell chain
   // ---------------------------------------------------------------------------------
   prfl_pkg::chain_type    chain [FRAMES+1];
   prfl_pkg::chain_type    sel   [FRAMES];
   logic [PAGE_BITS-1:0]   page_arr [FRAMES];
   logic [RW-1:0]          rank_arr [FRAMES];
   prfl_pkg::cell_cmd_type cmd;
   logic [FRAMES-1:0]      target_vec;
   logic [FRAMES-1:0]      lru_cand;
   logic [RW-1:0]          limit;

   assign chain[0] = '0;

   for (genvar g = 0; g < int'(FRAMES); g++) begin : g_cell
      prfl_cell #(
         .FRAMES    (FRAMES),
         .PAGE_BITS (PAGE_BITS),
         .RW        (RW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .key       (key_ff),
         .limit     (limit),
         .cmd       (cmd),
         .target    (target_vec[g]),
         .in_range  (in_range[g]),
         .cand      (lru_cand[g]),
         .chain_in  (chain[g]),
         .chain_out (chain[g+1]),
         .sel       (sel[g]),
         .page      (page_arr[g]),
         .rank      (rank_arr[g])
      );
   end

   // LRU victim: narrow the managed frames to those with the highest rank, MSB first;
   // the chain then keeps the lowest index among them.
   always_comb begin
      logic [FRAMES-1:0] bitvec;
      lru_cand = in_range;
      for (int b = int'(RW) - 1; b >= 0; b--) begin
         for (int i = 0; i < int'(FRAMES); i++) begin
            bitvec[i] = rank_arr[i][b];
         end
         if (|(lru_cand & bitvec)) begin
            lru_cand = lru_cand & bitvec;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Frame choice
   // ---------------------------------------------------------------------------------
   logic [FRAMES-1:0] hit_sel, free_sel, lru_sel;
   logic              hit_any, free_any, evict;
   logic [FW-1:0]     ptr_use;
   logic [FW-1:0]     frame_idx;
   logic [PAGE_BITS-1:0] old_page;

   always_comb begin
      for (int i = 0; i < int'(FRAMES); i++) begin
         hit_sel[i]  = sel[i].hit;
         free_sel[i] = sel[i].free;
         lru_sel[i]  = sel[i].lru;
      end
   end

   assign hit_any  = |hit_sel;
   assign free_any = |free_sel;
   assign evict    = !hit_any && !free_any;
   // Wrap a stale FIFO pointer left over from a larger frame count
   assign ptr_use  = (int'(fifo_ptr_ff) >= int'(n_frames)) ? '0 : fifo_ptr_ff;

   always_comb begin
      priority if (hit_any) begin
         target_vec = hit_sel;
      end else if (free_any) begin
         target_vec = free_sel;
      end else if (mode_ff == prfl_pkg::MODE_LRU) begin
         target_vec = lru_sel;
      end else begin
         for (int i = 0; i < int'(FRAMES); i++) begin
            target_vec[i] = (ptr_use == FW'(i));
         end
      end
   end

   always_comb begin
      frame_idx = '0;
      for (int i = 0; i < int'(FRAMES); i++) begin
         if (target_vec[i]) begin
            frame_idx = frame_idx | FW'(i);
         end
      end
   end

   assign limit    = rank_arr[frame_idx];
   assign old_page = page_arr[frame_idx];

   always_comb begin
      cmd.touch = look;
      cmd.load  = !hit_any;
      cmd.fill  = !hit_any && free_any;
   end

   // ---------------------------------------------------------------------------------
   // Pointer and counters advance at the end of the lookup cycle
   // ---------------------------------------------------------------------------------
   always_comb begin
      fifo_ptr_in = fifo_ptr_ff;
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      repl_cnt_in = repl_cnt_ff;
      if (look) begin
         if (hit_any) begin
            hit_cnt_in = sat_inc(hit_cnt_ff);
         end else begin
            miss_cnt_in = sat_inc(miss_cnt_ff);
            fifo_ptr_in = (int'(frame_idx) + 1 >= int'(n_frames)) ? '0 : frame_idx + 1'b1;
            if (evict) begin
               repl_cnt_in = sat_inc(repl_cnt_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= prfl_pkg::ST_IDLE;
         mode_ff     <= prfl_pkg::MODE_FIFO;
         nfr_ff      <= prfl_pkg::FRAMES_RESET;
         fifo_ptr_ff <= '0;
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
         repl_cnt_ff <= '0;
         rsp_valid   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fifo_ptr_ff <= fifo_ptr_in;
         hit_cnt_ff  <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
         repl_cnt_ff <= repl_cnt_in;
         rsp_valid   <= look;
         if (csr_valid && csr_ready) begin
            if (csr_index == prfl_pkg::CSR_MODE) begin
               mode_ff <= csr_wdata[0];
            end else if (csr_index == prfl_pkg::CSR_FRAMES) begin
               nfr_ff <= csr_wdata;
            end
         end
      end
   end

   // Capture the key on accept; register the result beat at the end of lookup
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= PAGE_BITS'(req_page_number);
      end
      if (look) begin
         rsp_is_hit        <= hit_any;
         rsp_frame_index   <= 4'(frame_idx);
         rsp_evicted_valid <= evict;
         rsp_evicted_page  <= evict ? 20'(old_page) : '0;
      end
   end

   assign rsp_hit_total     = hit_cnt_ff;
   assign rsp_miss_total    = miss_cnt_ff;
   assign rsp_replace_total = repl_cnt_ff;

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------
   a_beat_after_look: assert property (@(posedge clock) disable iff (reset)
      look |=> rsp_valid)
      else $error("lookup cycle did not produce a result beat");

   a_beat_only_after_look: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(look))
      else $error("result beat without a lookup");

   a_single_target: assert property (@(posedge clock) disable iff (reset)
      look |-> $onehot(target_vec))
      else $error("update target is not exactly one frame");

   a_no_evict_on_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_hit && rsp_evicted_valid))
      else $error("eviction reported on a hit");

endmodule

`default_nettype wire

// ----- src/prfl_cell.sv -----
// One frame cell: page tag, valid bit, recency rank and its link in the priority chain.
`timescale 1ns / 1ps
`default_nettype none

module prfl_cell #(
   parameter int unsigned FRAMES    = prfl_pkg::DEF_FRAMES,
   parameter int unsigned PAGE_BITS = prfl_pkg::DEF_PAGE_BITS,
   parameter int unsigned RW        = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [PAGE_BITS-1:0]   key,
   input  wire logic [RW-1:0]          limit,
   input  wire prfl_pkg::cell_cmd_type cmd,
   input  wire logic                   target,
   input  wire logic                   in_range,
   input  wire logic                   cand,
   input  wire prfl_pkg::chain_type    chain_in,
   output prfl_pkg::chain_type         chain_out,
   output prfl_pkg::chain_type         sel,
   output logic [PAGE_BITS-1:0]        page,
   output logic [RW-1:0]               rank
);

   logic                 valid_ff, valid_in;
   logic [RW-1:0]        rank_ff, rank_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 my_hit, my_free;

   assign my_hit  = valid_ff && in_range && (page_ff == key);
   assign my_free = !valid_ff && in_range;

   // First claimant in the chain wins; pass the seen flags right
   always_comb begin
      sel.hit        = my_hit && !chain_in.hit;
      sel.free       = my_free && !chain_in.free;
      sel.lru        = cand && !chain_in.lru;
      chain_out.hit  = chain_in.hit || my_hit;
      chain_out.free = chain_in.free || my_free;
      chain_out.lru  = chain_in.lru || cand;
   end

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      page_in  = page_ff;
      if (cmd.touch) begin
         if (target) begin
            rank_in = '0;
            if (cmd.load) begin
               valid_in = 1'b1;
               page_in  = key;
            end
         end else if (valid_ff && in_range && (cmd.fill || (rank_ff < limit)) &&
                      (int'(rank_ff) < int'(FRAMES) - 1)) begin
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

   assign page = page_ff;
   assign rank = rank_ff;

endmodule

`default_nettype wire
